### rtl/mkds_pkg.sv
// Shared types, codes and helper functions of the key matrix debounce scanner.
package mkds_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int TIMES_W   = 7;
  localparam int CNT_W     = 8;
  localparam int KEY_IDX_W = 4;
  localparam int COL_CNT_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] KEY_BASE = 8'h80;

  localparam logic [SAMPLE_W-1:0] ADC_TRIGGER_RST   = 10'd512;
  localparam logic [TIMES_W-1:0]  PRESS_TIMES_RST   = 7'd3;
  localparam logic [TIMES_W-1:0]  RELEASE_TIMES_RST = 7'd3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_TRIGGER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIMES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMES = 2'd2;

  // Commands of a scan item.
  localparam logic CMD_SCAN   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_HOLD    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_DRIVE   = 2'd3;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
  } item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [KEY_IDX_W-1:0] key_index;
    logic [COL_CNT_W-1:0] drive_column;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SAMPLE_W-1:0]  value;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_DRIVE,
    ST_REPORT,
    ST_FLUSH
  } state_t;

  // Picks the sample of one row out of a scan item.
  function automatic logic [SAMPLE_W-1:0] sample_of(item_t it, logic [1:0] r);
    logic [SAMPLE_W-1:0] s;
    unique case (r)
      2'd0:    s = it.sample_0;
      2'd1:    s = it.sample_1;
      2'd2:    s = it.sample_2;
      default: s = it.sample_3;
    endcase
    return s;
  endfunction

  // One debounce step: moves the counter toward hi while pressed and toward lo
  // otherwise, jumping back to the center first on a change of direction.
  function automatic logic [CNT_W-1:0] next_counter(logic [CNT_W-1:0] cnt, logic pressed,
                                                    logic [CNT_W-1:0] hi,
                                                    logic [CNT_W-1:0] lo);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (pressed) begin
      if (cnt < KEY_BASE) begin
        res = KEY_BASE;
      end else if (cnt < hi) begin
        res = cnt + 8'd1;
      end
    end else begin
      if (cnt > KEY_BASE) begin
        res = KEY_BASE;
      end else if (cnt > lo) begin
        res = cnt - 8'd1;
      end
    end
    return res;
  endfunction

endpackage

### rtl/mkds_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
interface mkds_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/matrix_key_debounce_scanner_unit.sv
// Top level of the key matrix scanner with per-key debounce counters.
//
// The block takes scan items on the items channel and delivers result beats
// on the results channel; both are valid/ready channels. A scan item (cmd 0)
// carries one ADC sample per row of the driven column. The block updates the
// debounce counters of that column, one row at a time with a read and then a
// write of the counter memory, and then returns one drive update beat. Once
// every column is scanned the next scan item restarts at column 0. A report
// item (cmd 1) after a full scan walks all keys row by row, one key per cycle
// through the memory read port while the walk is not held, and returns press,
// hold and release beats; the last beat carries last. Items are handled one
// at a time; the next item is taken while the final result still waits in the
// output register. A stalled receiver holds the walk at the next event that
// needs the output register.
// Reset restores the register defaults, marks every counter as the center
// value through per-key valid bits, clears the pressed map and the column.
// Configuration writes are always taken and should be made while idle.
module matrix_key_debounce_scanner_unit #(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input logic       clk,
  input logic       rst,
  mkds_chan_if.sink   items,
  mkds_chan_if.source results,
  mkds_chan_if.sink   cfg
);

  localparam int KEYS   = ROWS * COLS;
  localparam int ADDR_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;

  // Configuration registers.
  logic [mkds_pkg::SAMPLE_W-1:0] adc_trigger;
  logic [mkds_pkg::TIMES_W-1:0]  press_times;
  logic [mkds_pkg::TIMES_W-1:0]  release_times;

  // Control state.
  mkds_pkg::state_t state, state_next;
  logic [mkds_pkg::COL_CNT_W-1:0] col_cnt;
  logic [ROW_W-1:0]               row;
  logic [ROW_W-1:0]               walk_r;
  logic [COL_W-1:0]               walk_c;
  logic                           walk_done;
  logic                           chk_v;
  logic [ADDR_W-1:0]              chk_addr;
  logic                           hold_valid;
  logic [1:0]                     hold_kind;
  logic [ADDR_W-1:0]              hold_addr;
  logic                           out_valid;
  mkds_pkg::result_t              out_q;
  logic [KEYS-1:0]                pressed;

  // Samples of the accepted scan item.
  logic [mkds_pkg::SAMPLE_W-1:0] samples_q [ROWS];

  // Counter memory with per-key valid bits; an entry never written reads as
  // the center value.
  logic [mkds_pkg::CNT_W-1:0] key_mem [KEYS];
  logic [KEYS-1:0]            key_valid;
  logic [mkds_pkg::CNT_W-1:0] rd_data;
  logic                       rd_valid;

  // Control outputs of the state machine.
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic              mem_wr_en;
  logic              walk_adv;
  logic              rep_read;
  logic              out_load;
  mkds_pkg::result_t out_data;

  // Datapath terms.
  logic                          accept;
  logic                          scan_open;
  logic                          slot_free;
  logic [mkds_pkg::CNT_W-1:0]    press_hi;
  logic [mkds_pkg::CNT_W-1:0]    release_lo;
  logic [mkds_pkg::CNT_W-1:0]    cur_cnt;
  logic [mkds_pkg::CNT_W-1:0]    new_cnt;
  logic [mkds_pkg::SAMPLE_W-1:0] sample_cur;
  logic [ADDR_W-1:0]             scan_addr;
  logic [ADDR_W-1:0]             walk_addr;
  logic                          hit_press;
  logic                          hit_release;
  logic                          chk_event;
  logic [1:0]                    chk_kind;
  logic                          stall;
  logic                          row_last;
  logic                          walk_r_last;
  logic                          walk_c_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_trigger   <= mkds_pkg::ADC_TRIGGER_RST;
      press_times   <= mkds_pkg::PRESS_TIMES_RST;
      release_times <= mkds_pkg::RELEASE_TIMES_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        mkds_pkg::CFG_ADC_TRIGGER:   adc_trigger   <= cfg.data.value;
        mkds_pkg::CFG_PRESS_TIMES:   press_times   <= cfg.data.value[mkds_pkg::TIMES_W-1:0];
        mkds_pkg::CFG_RELEASE_TIMES: release_times <= cfg.data.value[mkds_pkg::TIMES_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = items.valid && items.ready;
  assign scan_open  = col_cnt < mkds_pkg::COL_CNT_W'(COLS);
  assign slot_free  = !out_valid || results.ready;
  assign press_hi   = mkds_pkg::KEY_BASE + {1'b0, press_times};
  assign release_lo = mkds_pkg::KEY_BASE - {1'b0, release_times};
  assign cur_cnt    = rd_valid ? rd_data : mkds_pkg::KEY_BASE;

  assign sample_cur = samples_q[row];
  assign new_cnt    = mkds_pkg::next_counter(cur_cnt, sample_cur < adc_trigger,
                                             press_hi, release_lo);
  assign scan_addr  = ADDR_W'(32'(col_cnt) * ROWS + 32'(row));
  assign walk_addr  = ADDR_W'(32'(walk_c) * ROWS + 32'(walk_r));

  assign row_last    = row == ROW_W'(ROWS - 1);
  assign walk_r_last = walk_r == ROW_W'(ROWS - 1);
  assign walk_c_last = walk_c == COL_W'(COLS - 1);

  // The press test wins over the release test.
  assign hit_press   = cur_cnt == press_hi;
  assign hit_release = (cur_cnt == release_lo) && pressed[chk_addr];
  assign chk_event   = hit_press || hit_release;
  assign chk_kind    = hit_press ? (pressed[chk_addr] ? mkds_pkg::KIND_HOLD
                                                      : mkds_pkg::KIND_PRESS)
                                 : mkds_pkg::KIND_RELEASE;

  // An event is kept back in the hold register until the next one shows up,
  // so that the final event can be marked last. Pushing the held event out
  // needs the output register.
  assign stall = chk_v && chk_event && hold_valid && !slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      mkds_pkg::ST_IDLE: begin
        if (accept) begin
          if (items.data.cmd == mkds_pkg::CMD_SCAN) begin
            state_next = scan_open ? mkds_pkg::ST_SCAN_RD : mkds_pkg::ST_DRIVE;
          end else if (!scan_open) begin
            state_next = mkds_pkg::ST_REPORT;
          end
        end
      end
      mkds_pkg::ST_SCAN_RD: state_next = mkds_pkg::ST_SCAN_WR;
      mkds_pkg::ST_SCAN_WR: state_next = row_last ? mkds_pkg::ST_DRIVE : mkds_pkg::ST_SCAN_RD;
      mkds_pkg::ST_DRIVE: begin
        if (slot_free) begin
          state_next = mkds_pkg::ST_IDLE;
        end
      end
      mkds_pkg::ST_REPORT: begin
        if (walk_done && !stall) begin
          state_next = mkds_pkg::ST_FLUSH;
        end
      end
      mkds_pkg::ST_FLUSH: begin
        if (!hold_valid || slot_free) begin
          state_next = mkds_pkg::ST_IDLE;
        end
      end
      default: state_next = mkds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = scan_addr;
    mem_wr_en   = 1'b0;
    walk_adv    = 1'b0;
    rep_read    = 1'b0;
    out_load    = 1'b0;
    out_data    = '{kind: hold_kind,
                    key_index: mkds_pkg::KEY_IDX_W'(hold_addr),
                    drive_column: mkds_pkg::COL_CNT_W'(COLS),
                    last: 1'b0};
    unique case (state)
      mkds_pkg::ST_IDLE: items.ready = 1'b1;
      mkds_pkg::ST_SCAN_RD: mem_rd_en = 1'b1;
      mkds_pkg::ST_SCAN_WR: mem_wr_en = 1'b1;
      mkds_pkg::ST_DRIVE: begin
        out_load = slot_free;
        out_data = '{kind: mkds_pkg::KIND_DRIVE,
                     key_index: '0,
                     drive_column: col_cnt,
                     last: 1'b1};
      end
      mkds_pkg::ST_REPORT: begin
        walk_adv    = !stall;
        rep_read    = !stall && !walk_done;
        mem_rd_en   = rep_read;
        mem_rd_addr = walk_addr;
        out_load    = chk_v && chk_event && hold_valid && slot_free;
      end
      mkds_pkg::ST_FLUSH: begin
        out_load      = hold_valid && slot_free;
        out_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mkds_pkg::ST_IDLE;
      col_cnt    <= '0;
      row        <= '0;
      walk_r     <= '0;
      walk_c     <= '0;
      walk_done  <= 1'b0;
      chk_v      <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      pressed    <= '0;
      key_valid  <= '0;
      rd_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        row       <= '0;
        walk_r    <= '0;
        walk_c    <= '0;
        walk_done <= 1'b0;
        chk_v     <= 1'b0;
        if (items.data.cmd == mkds_pkg::CMD_SCAN && !scan_open) begin
          col_cnt <= '0;
        end
      end

      if (mem_rd_en) begin
        rd_valid <= key_valid[mem_rd_addr];
      end

      if (mem_wr_en) begin
        key_valid[scan_addr] <= 1'b1;
        row <= row + ROW_W'(1);
        if (row_last) begin
          col_cnt <= col_cnt + mkds_pkg::COL_CNT_W'(1);
        end
      end

      if (rep_read) begin
        if (walk_c_last) begin
          walk_c <= '0;
          if (walk_r_last) begin
            walk_done <= 1'b1;
          end else begin
            walk_r <= walk_r + ROW_W'(1);
          end
        end else begin
          walk_c <= walk_c + COL_W'(1);
        end
      end

      if (walk_adv) begin
        chk_v <= rep_read;
        if (chk_v && chk_event) begin
          pressed[chk_addr] <= chk_kind != mkds_pkg::KIND_RELEASE;
          hold_valid        <= 1'b1;
        end
      end

      if (state == mkds_pkg::ST_FLUSH && out_load) begin
        hold_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int r = 0; r < ROWS; r++) begin
        samples_q[r] <= mkds_pkg::sample_of(items.data, 2'(r));
      end
    end
    if (rep_read) begin
      chk_addr <= walk_addr;
    end
    if (walk_adv && chk_v && chk_event) begin
      hold_kind <= chk_kind;
      hold_addr <= chk_addr;
    end
    if (out_load) begin
      out_q <= out_data;
    end
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      key_mem[scan_addr] <= new_cnt;
    end
    if (mem_rd_en) begin
      rd_data <= key_mem[mem_rd_addr];
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_q;

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> slot_free)
    else $error("result register loaded while a beat still waits");

  a_report_read_only: assert property (@(posedge clk) disable iff (rst)
    state == mkds_pkg::ST_REPORT |-> !mem_wr_en && !scan_open)
    else $error("counter memory written or scan open during the report walk");

  a_hold_in_report: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (state == mkds_pkg::ST_REPORT || state == mkds_pkg::ST_FLUSH))
    else $error("held event outside the report walk");

endmodule

### test/matrix_key_debounce_scanner_unit_test.sv
// Self-checking testbench of the key matrix scanner with per-key debounce counters.
`timescale 1ns / 100ps

module matrix_key_debounce_scanner_unit_test;

  localparam int KEY_ROWS = 4;
  localparam int KEY_COLS = 4;
  localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;

  // A report item walks every key, one per cycle unless stalled, so the block
  // can still be busy after the last due beat arrives; this tail covers that walk with margin.
  localparam int WALK_TAIL   = 40;
  localparam int DUE_WAIT    = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  // How a row of the directed script gets its expected beats.
  typedef enum logic [1:0] {
    BY_MODEL,   // expected beats come from the predictor
    NO_BEATS,   // the item must produce nothing
    DRIVE_TO    // one drive update to the column given in the row
  } check_t;

  typedef struct packed {
    mkds_pkg::item_t                beat;
    check_t                         how;
    logic [mkds_pkg::COL_CNT_W-1:0] col;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mkds_chan_if #(.payload_t(mkds_pkg::item_t))   items_ch ();
  mkds_chan_if #(.payload_t(mkds_pkg::result_t)) results_ch ();
  mkds_chan_if #(.payload_t(mkds_pkg::cfg_t))    cfg_ch ();

  matrix_key_debounce_scanner_unit #(
    .ROWS(KEY_ROWS),
    .COLS(KEY_COLS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: our own copy of the registers, the debounce counters,
  // the pressed map and the column that is driven next.
  int       trig_lvl;
  int       press_need;
  int       release_need;
  int       dbc_cnt [NUM_KEYS];
  bit       key_down [NUM_KEYS];
  int       col_at;

  // Beats produced by the last predicted item, and every beat still owed by the block.
  mkds_pkg::result_t  step_beats [$];
  mkds_pkg::result_t  beats_due [$];

  // Stimulus-side picture of which keys a finger is holding down right now.
  bit       finger [NUM_KEYS];

  int       mismatches = 0;
  int       cycle_cnt = 0;
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;
  bit       rx_hold_req = 1'b0;

  dir_row_t script [$];

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void keypad_reset();
    trig_lvl     = int'(mkds_pkg::ADC_TRIGGER_RST);
    press_need   = int'(mkds_pkg::PRESS_TIMES_RST);
    release_need = int'(mkds_pkg::RELEASE_TIMES_RST);
    foreach (dbc_cnt[i]) begin
      dbc_cnt[i]  = int'(mkds_pkg::KEY_BASE);
      key_down[i] = 1'b0;
      finger[i]   = 1'b0;
    end
    col_at = 0;
  endfunction

  // Works out the beats one accepted item causes and advances the predictor state.
  function automatic void keypad_step(mkds_pkg::item_t it);
    logic [mkds_pkg::SAMPLE_W-1:0] smp [4];
    int                            idx;
    int                            c;
    int                            row;
    int                            col;
    int                            base;
    bit                            emit;
    logic [1:0]                    kind;
    mkds_pkg::result_t             b;
    step_beats.delete();
    base = int'(mkds_pkg::KEY_BASE);
    smp = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3};
    if (it.cmd == mkds_pkg::CMD_SCAN) begin
      if (col_at < KEY_COLS) begin
        for (row = 0; row < KEY_ROWS; row++) begin
          idx = col_at * KEY_ROWS + row;
          c = dbc_cnt[idx];
          // A change of direction snaps the counter back to the center first.
          if (int'(smp[row]) < trig_lvl) begin
            if (c < base) c = base;
            else if (c < base + press_need) c++;
          end else begin
            if (c > base) c = base;
            else if (c > base - release_need) c--;
          end
          dbc_cnt[idx] = c;
        end
        col_at++;
      end else begin
        col_at = 0;
      end
      b.kind         = mkds_pkg::KIND_DRIVE;
      b.key_index    = '0;
      b.drive_column = 3'(col_at);
      b.last         = 1'b1;
      step_beats.push_back(b);
    end else if (col_at >= KEY_COLS) begin
      // Row-major walk; the press level is tested before the release level.
      for (row = 0; row < KEY_ROWS; row++) begin
        for (col = 0; col < KEY_COLS; col++) begin
          idx  = col * KEY_ROWS + row;
          emit = 1'b0;
          kind = mkds_pkg::KIND_PRESS;
          if (dbc_cnt[idx] == base + press_need) begin
            emit = 1'b1;
            kind = key_down[idx] ? mkds_pkg::KIND_HOLD : mkds_pkg::KIND_PRESS;
            key_down[idx] = 1'b1;
          end else if (dbc_cnt[idx] == base - release_need && key_down[idx]) begin
            emit = 1'b1;
            kind = mkds_pkg::KIND_RELEASE;
            key_down[idx] = 1'b0;
          end
          if (emit) begin
            b.kind         = kind;
            b.key_index    = 4'(idx);
            b.drive_column = 3'(KEY_COLS);
            b.last         = 1'b0;
            step_beats.push_back(b);
          end
        end
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic dir_row_t row_of(logic cmd, int s0, int s1, int s2, int s3,
                                      check_t how, int col);
    dir_row_t r;
    r.beat.cmd      = cmd;
    r.beat.sample_0 = mkds_pkg::SAMPLE_W'(s0);
    r.beat.sample_1 = mkds_pkg::SAMPLE_W'(s1);
    r.beat.sample_2 = mkds_pkg::SAMPLE_W'(s2);
    r.beat.sample_3 = mkds_pkg::SAMPLE_W'(s3);
    r.how           = how;
    r.col           = mkds_pkg::COL_CNT_W'(col);
    return r;
  endfunction

  // A sample that mostly agrees with the finger, sometimes sits right on the
  // trigger edge and sometimes is plain noise over the whole range.
  function automatic logic [mkds_pkg::SAMPLE_W-1:0] pick_sample(bit down);
    int v;
    case ($urandom_range(9, 0))
      0: v = $urandom_range(1023, 0);
      1: v = (down && trig_lvl > 0) ? trig_lvl - 1 : trig_lvl;
      default: begin
        if (down && trig_lvl > 0) v = $urandom_range(trig_lvl - 1, 0);
        else if (down) v = $urandom_range(1023, 0);
        else v = $urandom_range(1023, trig_lvl);
      end
    endcase
    return mkds_pkg::SAMPLE_W'(v);
  endfunction

  function automatic mkds_pkg::item_t noise_item(logic cmd);
    mkds_pkg::item_t it;
    it.cmd      = cmd;
    it.sample_0 = mkds_pkg::SAMPLE_W'($urandom_range(1023, 0));
    it.sample_1 = mkds_pkg::SAMPLE_W'($urandom_range(1023, 0));
    it.sample_2 = mkds_pkg::SAMPLE_W'($urandom_range(1023, 0));
    it.sample_3 = mkds_pkg::SAMPLE_W'($urandom_range(1023, 0));
    return it;
  endfunction

  // Offers one item after a random gap and books its expected beats once the
  // item is taken. Valid stays high into the next item when there is no gap.
  task automatic send_item(mkds_pkg::item_t it, check_t how,
                           logic [mkds_pkg::COL_CNT_W-1:0] col);
    int                gap;
    mkds_pkg::result_t b;
    if ($urandom_range(24, 0) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    do @(posedge clk); while (!(items_ch.valid && items_ch.ready));
    keypad_step(it);
    case (how)
      BY_MODEL: begin
        foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
      end
      DRIVE_TO: begin
        b.kind         = mkds_pkg::KIND_DRIVE;
        b.key_index    = '0;
        b.drive_column = col;
        b.last         = 1'b1;
        beats_due.push_back(b);
      end
      default: begin
      end
    endcase
  endtask

  // Stops offering items, waits for every owed beat (bounded), then lets the
  // block finish any walk that produces nothing.
  task automatic settle(int tail);
    int waited;
    waited = 0;
    items_ch.valid <= 1'b0;
    while (beats_due.size() != 0 && waited < DUE_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (beats_due.size() != 0) begin
      flag_mismatch("results never delivered", 0, beats_due.size());
      beats_due.delete();
    end
    repeat (tail) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while the block is idle.
  task automatic set_regs(int trig, int press, int rel);
    mkds_pkg::cfg_t w;
    int             vals [3];
    vals = '{trig, press, rel};
    for (int i = 0; i < 3; i++) begin
      w.index = mkds_pkg::CFG_IDX_W'(i);
      w.value = mkds_pkg::SAMPLE_W'(vals[i]);
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= w;
      do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
      case (w.index)
        mkds_pkg::CFG_ADC_TRIGGER:   trig_lvl     = vals[i] & 1023;
        mkds_pkg::CFG_PRESS_TIMES:   press_need   = vals[i] & 127;
        mkds_pkg::CFG_RELEASE_TIMES: release_need = vals[i] & 127;
        default: begin
        end
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic: mostly complete scans of all columns followed by reports,
  // with stray reports in mid-scan and early restarts as noise. Stray reports
  // are ignored by the block and do not count toward n_items.
  task automatic run_random(int n_items, bit pause_mid);
    int              done;
    int              idx;
    bit              counts;
    mkds_pkg::item_t it;
    done = 0;
    while (done < n_items) begin
      counts = 1'b1;
      if (col_at < KEY_COLS) begin
        if ($urandom_range(9, 0) == 0) begin
          it = noise_item(mkds_pkg::CMD_REPORT);
          counts = 1'b0;
        end else begin
          it.cmd = mkds_pkg::CMD_SCAN;
          for (int r = 0; r < KEY_ROWS; r++) begin
            idx = col_at * KEY_ROWS + r;
            if ($urandom_range(9, 0) == 0) finger[idx] = !finger[idx];
          end
          it.sample_0 = pick_sample(finger[col_at * KEY_ROWS + 0]);
          it.sample_1 = pick_sample(finger[col_at * KEY_ROWS + 1]);
          it.sample_2 = pick_sample(finger[col_at * KEY_ROWS + 2]);
          it.sample_3 = pick_sample(finger[col_at * KEY_ROWS + 3]);
        end
      end else if ($urandom_range(4, 0) < 3) begin
        it = noise_item(mkds_pkg::CMD_REPORT);
      end else begin
        it = noise_item(mkds_pkg::CMD_SCAN);
      end
      send_item(it, BY_MODEL, '0);
      if (counts) done++;
      if (pause_mid && done == n_items / 2 && beats_due.size() != 0) begin
        // Sender pause: nothing is offered until the block has delivered everything.
        items_ch.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Receiver: a random stall before each beat, calm stretches without stalls,
  // and one long hold-off on request so that the block backs up into its input.
  initial begin
    int gap;
    results_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        results_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      if ($urandom_range(29, 0) == 0) rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(4, 0);
      if (gap > 0) begin
        results_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!(results_ch.valid && results_ch.ready));
    end
  end

  // Every delivered beat is matched against the oldest owed one, field by field.
  always @(posedge clk) begin
    mkds_pkg::result_t got;
    mkds_pkg::result_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = results_ch.data;
      if (beats_due.size() == 0) begin
        flag_mismatch("unexpected result beat, kind", got.kind, -1);
      end else begin
        want = beats_due.pop_front();
        if (got.kind != want.kind)
          flag_mismatch("kind", got.kind, want.kind);
        if (got.key_index != want.key_index)
          flag_mismatch("key_index", got.key_index, want.key_index);
        if (got.drive_column != want.drive_column)
          flag_mismatch("drive_column", got.drive_column, want.drive_column);
        if (got.last != want.last)
          flag_mismatch("last", got.last, want.last);
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[matrix_key_debounce_scanner_unit] ERROR");
      $finish;
    end
  end

  initial begin
    items_ch.valid <= 1'b0;
    items_ch.data  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    keypad_reset();

    // Directed script in the reset settings (trigger 512, three samples each way).
    // Column 0 gets samples right around the trigger, column 1 is held, column 2
    // released and column 3 alternates. Three full scans bring the held keys to
    // the press level; the reports then give presses and then holds.
    script = '{
      row_of(mkds_pkg::CMD_REPORT, 0, 0, 0, 0, NO_BEATS, 0),    // report before a full scan
      row_of(mkds_pkg::CMD_SCAN, 0, 511, 512, 1023, DRIVE_TO, 1),
      row_of(mkds_pkg::CMD_SCAN, 0, 0, 0, 0, DRIVE_TO, 2),
      row_of(mkds_pkg::CMD_SCAN, 1023, 1023, 1023, 1023, DRIVE_TO, 3),
      row_of(mkds_pkg::CMD_SCAN, 'h155, 'h2AA, 'h155, 'h2AA, DRIVE_TO, 4),
      row_of(mkds_pkg::CMD_REPORT, 'h3FF, 'h3FF, 'h3FF, 'h3FF, NO_BEATS, 0), // nothing settled
      row_of(mkds_pkg::CMD_SCAN, 'h2AA, 'h155, 'h3FF, 0, DRIVE_TO, 0),  // restart at column 0
      row_of(mkds_pkg::CMD_SCAN, 0, 511, 512, 1023, DRIVE_TO, 1),
      row_of(mkds_pkg::CMD_SCAN, 0, 0, 0, 0, DRIVE_TO, 2),
      row_of(mkds_pkg::CMD_SCAN, 1023, 1023, 1023, 1023, DRIVE_TO, 3),
      row_of(mkds_pkg::CMD_SCAN, 'h155, 'h2AA, 'h155, 'h2AA, DRIVE_TO, 4),
      row_of(mkds_pkg::CMD_REPORT, 0, 0, 0, 0, NO_BEATS, 0),
      row_of(mkds_pkg::CMD_SCAN, 0, 0, 0, 0, DRIVE_TO, 0),
      row_of(mkds_pkg::CMD_SCAN, 0, 511, 512, 1023, DRIVE_TO, 1),
      row_of(mkds_pkg::CMD_SCAN, 0, 0, 0, 0, DRIVE_TO, 2),
      row_of(mkds_pkg::CMD_SCAN, 1023, 1023, 1023, 1023, DRIVE_TO, 3),
      row_of(mkds_pkg::CMD_SCAN, 'h155, 'h2AA, 'h155, 'h2AA, DRIVE_TO, 4),
      row_of(mkds_pkg::CMD_REPORT, 0, 0, 0, 0, BY_MODEL, 0),          // first presses
      row_of(mkds_pkg::CMD_REPORT, 'h3FF, 0, 'h3FF, 0, BY_MODEL, 0),  // same keys now hold
      row_of(mkds_pkg::CMD_SCAN, 1023, 0, 1023, 0, DRIVE_TO, 0),
      row_of(mkds_pkg::CMD_SCAN, 1023, 1023, 1023, 1023, DRIVE_TO, 1),
      row_of(mkds_pkg::CMD_SCAN, 1023, 1023, 1023, 1023, DRIVE_TO, 2),
      row_of(mkds_pkg::CMD_SCAN, 0, 0, 0, 0, DRIVE_TO, 3),
      row_of(mkds_pkg::CMD_SCAN, 'h2AA, 'h155, 'h2AA, 'h155, DRIVE_TO, 4),
      row_of(mkds_pkg::CMD_REPORT, 0, 0, 0, 0, BY_MODEL, 0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_item(script[i].beat, script[i].how, script[i].col);
    run_random(12, 1'b0);
    settle(WALK_TAIL);

    // Fast debounce with a high trigger; the sender pauses halfway until drained.
    set_regs(700, 1, 1);
    run_random(24, 1'b1);
    settle(WALK_TAIL);

    // Largest counts and a trigger of zero: no sample counts as pressed.
    set_regs(0, 127, 127);
    run_random(8, 1'b0);
    settle(WALK_TAIL);

    // Zero press and release counts with the top trigger: a counter that reaches the
    // center stays there, and the center is the press level, so each report gives
    // every key at the center. The receiver holds off for a long stretch meanwhile.
    set_regs(1023, 0, 0);
    rx_hold_req = 1'b1;
    run_random(16, 1'b0);
    settle(WALK_TAIL);

    set_regs($urandom_range(900, 200), $urandom_range(4, 2), $urandom_range(3, 1));
    run_random(30, 1'b0);
    settle(WALK_TAIL);

    set_regs($urandom_range(1023, 0), 1, 2);
    run_random(24, 1'b0);
    settle(WALK_TAIL);

    if (mismatches == 0) begin
      $display("[matrix_key_debounce_scanner_unit] OK");
    end else begin
      $display("[matrix_key_debounce_scanner_unit] ERROR");
    end
    $finish;
  end

endmodule
